// File: rtl/cpmt_pkg.sv
// ----------------------------------------------------------------------------
// cpmt_pkg
// Shared types and constants for the client port mapping table.
// ----------------------------------------------------------------------------
package cpmt_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int SRV_W  = 8;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 1;

    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CIDX_W-1:0] t_cfg_idx;

    localparam t_status ST_HIT      = 2'd0;
    localparam t_status ST_NEW      = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_UNMAPPED = 2'd3;

    localparam t_cfg_idx CFG_BIND_BASE = 1'd0;
    localparam t_cfg_idx CFG_MAIN_SRV  = 1'd1;

    localparam logic [PORT_W-1:0] BIND_BASE_RST = 16'd40000;
    localparam logic [SRV_W-1:0]  MAIN_SRV_RST  = 8'd0;

    localparam logic REQ_FWD = 1'b0;
    localparam logic REQ_REV = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic    cap;     // capture the accepted request, restart scan
        logic    scan;    // advance the scan by one slot
        logic    rev_rd;  // read the slot addressed by the bound port
        logic    finish;  // load the result register
        t_status status;  // status to report on finish
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;     // scan found a matching slot
        logic miss;    // scan ran past the filled slots
        logic full;    // no free slot left
        logic rev_ok;  // bound port maps to a filled slot
    } t_sts;

endpackage

// File: rtl/cpmt_req_if.sv
// ----------------------------------------------------------------------------
// cpmt_req_if
// Request channel: valid/ready handshake with the lookup request payload.
// ----------------------------------------------------------------------------
interface cpmt_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [15:0] bound_port;

    modport source (output valid, output req_type, output client_addr,
                    output client_port, output bound_port, input ready);
    modport sink   (input valid, input req_type, input client_addr,
                    input client_port, input bound_port, output ready);
endinterface

// File: rtl/cpmt_rsp_if.sv
// ----------------------------------------------------------------------------
// cpmt_rsp_if
// Response channel: valid/ready handshake with the lookup result payload.
// ----------------------------------------------------------------------------
interface cpmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] slot_port;
    logic [7:0]  server_number;
    logic [31:0] entry_addr;
    logic [15:0] entry_port;

    modport source (output valid, output status, output slot, output slot_port,
                    output server_number, output entry_addr, output entry_port,
                    input ready);
    modport sink   (input valid, input status, input slot, input slot_port,
                    input server_number, input entry_addr, input entry_port,
                    output ready);
endinterface

// File: rtl/client_port_mapping_table.sv
// Forward request: the scan compares one slot per cycle through the slot
// memory port, from slot 0 to the first hit, or over all F filled slots (at
// most NUM_SLOTS) on a miss or a new entry. Reverse request: one read of the
// slot at the bound port's offset. One request at a time; a response held at
// the output delays the result load, and the next request is taken the cycle
// after. Reset (synchronous, active low) empties the table and restores config.
module client_port_mapping_table
    import cpmt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    cpmt_req_if.sink         i_req,
    cpmt_rsp_if.source       o_rsp
);

    t_cmd cmd;
    t_sts sts;

    cpmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cpmt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req.req_type),
        .i_client_addr   (i_req.client_addr),
        .i_client_port   (i_req.client_port),
        .i_bound_port    (i_req.bound_port),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_rsp.status),
        .o_slot          (o_rsp.slot),
        .o_slot_port     (o_rsp.slot_port),
        .o_server_number (o_rsp.server_number),
        .o_entry_addr    (o_rsp.entry_addr),
        .o_entry_port    (o_rsp.entry_port)
    );

endmodule

// File: rtl/cpmt_ctrl.sv
// ----------------------------------------------------------------------------
// cpmt_ctrl
// Sequencer: accepts a request, runs the slot scan or the reverse read,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module cpmt_ctrl
    import cpmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_type,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_REV   = 2'd2;
    localparam logic [1:0] S_RWAIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign out_free    = !r_out_vld || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.status  = ST_HIT;
        o_cmd.cap     = i_req_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_type == REQ_REV) ? S_REV : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.miss) begin
                    if (out_free) begin
                        o_cmd.finish = 1'b1;
                        if (i_sts.hit) begin
                            o_cmd.status = ST_HIT;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.status = ST_NEW;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_REV: begin
                o_cmd.rev_rd = 1'b1;
                n_state      = S_RWAIT;
            end
            S_RWAIT: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_sts.rev_ok ? ST_HIT : ST_UNMAPPED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.finish) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// File: rtl/cpmt_dp.sv
// ----------------------------------------------------------------------------
// cpmt_dp
// Datapath: slot memory, fill count, scan counter and compare, config
// registers and the result register.
// ----------------------------------------------------------------------------
module cpmt_dp
    import cpmt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_client_addr,
    input  logic [PORT_W-1:0] i_client_port,
    input  logic [PORT_W-1:0] i_bound_port,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output t_status           o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [PORT_W-1:0] o_slot_port,
    output logic [SRV_W-1:0]  o_server_number,
    output logic [ADDR_W-1:0] o_entry_addr,
    output logic [PORT_W-1:0] o_entry_port
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);

    // slot memory, one word per slot
    logic [ADDR_W-1:0] mem_addr [NUM_SLOTS];
    logic [PORT_W-1:0] mem_port [NUM_SLOTS];
    logic [SRV_W-1:0]  mem_srv  [NUM_SLOTS];

    logic [PORT_W-1:0] r_base;
    logic [SRV_W-1:0]  r_main_srv;

    logic              r_req_type;
    logic [ADDR_W-1:0] r_key_addr;
    logic [PORT_W-1:0] r_key_port;
    logic [PORT_W-1:0] r_bport;

    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;

    logic [ADDR_W-1:0] r_rd_addr;
    logic [PORT_W-1:0] r_rd_port;
    logic [SRV_W-1:0]  r_rd_srv;

    logic [PORT_W-1:0] offset;
    logic              issue;
    logic              rd_en;
    logic [IW-1:0]     rd_idx;
    logic              wr_en;
    logic [PORT_W-1:0] res_idx;

    assign offset = r_bport - r_base;
    assign issue  = (r_idx < r_fill);

    assign o_sts.hit    = r_cmp_vld && (r_rd_addr == r_key_addr)
                                    && (r_rd_port == r_key_port);
    assign o_sts.miss   = !r_cmp_vld && !issue;
    assign o_sts.full   = (r_fill == FULL_CNT);
    assign o_sts.rev_ok = (offset < PORT_W'(r_fill));

    assign rd_en  = (i_cmd.scan && issue) || i_cmd.rev_rd;
    assign rd_idx = i_cmd.rev_rd ? offset[IW-1:0] : r_idx[IW-1:0];
    assign wr_en  = i_cmd.finish && (i_cmd.status == ST_NEW);

    always_comb begin
        if (r_req_type == REQ_REV) begin
            res_idx = offset;
        end else if (i_cmd.status == ST_NEW) begin
            res_idx = PORT_W'(r_fill);
        end else begin
            res_idx = PORT_W'(r_cmp_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_addr[r_fill[IW-1:0]] <= r_key_addr;
            mem_port[r_fill[IW-1:0]] <= r_key_port;
            mem_srv[r_fill[IW-1:0]]  <= r_main_srv;
        end
        if (rd_en) begin
            r_rd_addr <= mem_addr[rd_idx];
            r_rd_port <= mem_port[rd_idx];
            r_rd_srv  <= mem_srv[rd_idx];
        end
    end

    // control state: config, fill count, scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BIND_BASE_RST;
            r_main_srv <= MAIN_SRV_RST;
            r_fill     <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIND_BASE: r_base     <= i_cfg_data[PORT_W-1:0];
                    CFG_MAIN_SRV:  r_main_srv <= i_cfg_data[SRV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.cap) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (wr_en) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req_type <= i_req_type;
            r_key_addr <= i_client_addr;
            r_key_port <= i_client_port;
            r_bport    <= i_bound_port;
        end
        if (i_cmd.scan && issue) begin
            r_cmp_idx <= r_idx[IW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status <= i_cmd.status;
            case (i_cmd.status)
                ST_HIT: begin
                    o_slot          <= res_idx[SLOT_W-1:0];
                    o_slot_port     <= r_base + res_idx;
                    o_server_number <= r_rd_srv;
                    o_entry_addr    <= r_rd_addr;
                    o_entry_port    <= r_rd_port;
                end
                ST_NEW: begin
                    o_slot          <= res_idx[SLOT_W-1:0];
                    o_slot_port     <= r_base + res_idx;
                    o_server_number <= r_main_srv;
                    o_entry_addr    <= r_key_addr;
                    o_entry_port    <= r_key_port;
                end
                default: begin
                    o_slot          <= '0;
                    o_slot_port     <= '0;
                    o_server_number <= '0;
                    o_entry_addr    <= '0;
                    o_entry_port    <= '0;
                end
            endcase
        end
    end

endmodule
